/* hdl/int128_signed_alu_core_assert.svh */
// Assertion macros for the signed ALU checker.
// Included by the checker file; no other dependencies.
`ifndef INT128_SIGNED_ALU_CORE_ASSERT_SVH
`define INT128_SIGNED_ALU_CORE_ASSERT_SVH
// Implication check, disabled during reset.
`define ALU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("alu check failed");
// Next-cycle check, disabled during reset.
`define ALU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("alu check failed");
`endif

/* hdl/i128alu_pkg.sv */
// Package for the signed ALU: codes, payload structs, shared constants.
// No dependencies.
package i128alu_pkg;
  localparam int unsigned WordBitsDefault = 128;
  localparam int unsigned HalfBits = 64;
  localparam int unsigned FullBits = 128;

  localparam logic [3:0] FuncAdd = 4'd0;
  localparam logic [3:0] FuncSub = 4'd1;
  localparam logic [3:0] FuncNeg = 4'd2;
  localparam logic [3:0] FuncMul = 4'd3;
  localparam logic [3:0] FuncDiv = 4'd4;
  localparam logic [3:0] FuncRem = 4'd5;
  localparam logic [3:0] FuncLess = 4'd6;
  localparam logic [3:0] FuncEqual = 4'd7;
  localparam logic [3:0] FuncShl = 4'd8;
  localparam logic [3:0] FuncShr = 4'd9;

  typedef struct packed {
    logic [3:0] func;
    logic signed [63:0] a_hi;
    logic [63:0] a_lo;
    logic signed [63:0] b_hi;
    logic [63:0] b_lo;
    logic [6:0] shift_amount;
  } alu_in_t;

  typedef struct packed {
    logic signed [63:0] res_hi;
    logic [63:0] res_lo;
    logic div_zero;
  } alu_out_t;

  // Step commands from sequencer to the shared datapath.
  typedef struct packed {
    logic load;
    logic div_step;
    logic mul_step;
    logic finish;
  } alu_ctl_t;
endpackage

/* hdl/i128alu_datapath.sv */
// Datapath: trial subtractor and accumulate adder, shift-by-one registers.
// Serves multiply (shift-add), divide (restoring) and the other functions. Uses i128alu_pkg.
module i128alu_datapath #(
  parameter int unsigned WORD_BITS = i128alu_pkg::WordBitsDefault
) (
  input  logic                   clk,
  input  i128alu_pkg::alu_ctl_t  ctl,
  input  i128alu_pkg::alu_in_t   item,
  output i128alu_pkg::alu_out_t  result
);
  import i128alu_pkg::*;

  localparam int unsigned W = WORD_BITS;

  logic [W-1:0] a, b, acc, acc_next, qb, qb_next, opb;
  logic [3:0] func;
  logic [6:0] sh;
  logic an, bn, dz;
  logic [W-1:0] ain, bin, aabs, babs;
  logic [W:0] trial;
  logic [W-1:0] fin;
  logic [FullBits-1:0] fin_ext;
  logic [W-1:0] sum;

  assign ain = W'({item.a_hi, item.a_lo});
  assign bin = W'({item.b_hi, item.b_lo});
  assign aabs = ain[W-1] ? (~ain + W'(1)) : ain;
  assign babs = bin[W-1] ? (~bin + W'(1)) : bin;

  // Iteration step: divide trial subtract or multiply accumulate.
  always_comb begin
    trial = {acc, qb[W-1]} - {1'b0, opb};
    sum = acc + opb;
    acc_next = acc;
    qb_next = qb;
    if (ctl.div_step) begin
      if (!trial[W]) acc_next = trial[W-1:0];
      else acc_next = {acc[W-2:0], qb[W-1]};
      qb_next = {qb[W-2:0], ~trial[W]};
    end else if (ctl.mul_step) begin
      // qb holds remaining multiplier bits, opb the shifted multiplicand.
      if (qb[0]) acc_next = sum;
      qb_next = qb >> 1;
    end
  end

  // Finish: pick result per func and sign-fix.
  always_comb begin
    fin = '0;
    case (func)
      FuncAdd: fin = a + b;
      FuncSub: fin = a - b;
      FuncNeg: fin = ~a + W'(1);
      FuncMul: fin = acc;
      FuncDiv: fin = dz ? '0 : ((an ^ bn) ? (~qb + W'(1)) : qb);
      FuncRem: fin = dz ? '0 : (an ? (~acc + W'(1)) : acc);
      FuncLess: fin = W'($signed(a) < $signed(b));
      FuncEqual: fin = W'(a == b);
      FuncShl: fin = (32'(sh) >= W) ? '0 : (a << sh);
      FuncShr: fin = (32'(sh) >= W) ? '0 : (a >> sh);
      default: fin = '0;
    endcase
  end

  // Sign-extend the word result to the full output width.
  assign fin_ext = FullBits'($signed(fin));

  // Hold operands, advance iteration registers.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      func <= item.func;
      sh <= item.shift_amount;
      a <= ain;
      b <= bin;
      an <= ain[W-1];
      bn <= bin[W-1];
      dz <= (bin == '0) && (item.func == FuncDiv || item.func == FuncRem);
      acc <= '0;
      if (item.func == FuncMul) begin
        qb <= bin;
        opb <= ain;
      end else begin
        qb <= aabs;
        opb <= babs;
      end
    end else begin
      acc <= acc_next;
      qb <= qb_next;
      if (ctl.mul_step) opb <= opb << 1;
    end
    if (ctl.finish) begin
      result.res_hi <= fin_ext[FullBits-1:HalfBits];
      result.res_lo <= fin_ext[HalfBits-1:0];
      result.div_zero <= dz;
    end
  end
endmodule

/* hdl/i128alu_seq.sv */
// Sequencer: load, WORD_BITS steps for mul/div/rem, finish, then output.
// Uses i128alu_pkg.
module i128alu_seq #(
  parameter int unsigned WORD_BITS = i128alu_pkg::WordBitsDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [3:0]            in_func,
  input  logic                  out_stall,
  output logic                  in_stall,
  output logic                  out_valid,
  output i128alu_pkg::alu_ctl_t ctl
);
  import i128alu_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_FIN, S_OUT} state_t;
  state_t state;
  logic [$clog2(WORD_BITS+1)-1:0] cnt;

  assign in_stall = (state != S_IDLE);
  always_comb begin
    ctl.load = (state == S_IDLE) && in_valid;
    ctl.mul_step = (state == S_MUL);
    ctl.div_step = (state == S_DIV);
    ctl.finish = (state == S_FIN);
  end

  // Hold state, count iterations, register output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          cnt <= '0;
          if (in_func == FuncMul) state <= S_MUL;
          else if (in_func == FuncDiv || in_func == FuncRem) state <= S_DIV;
          else state <= S_FIN;
        end
        S_MUL, S_DIV: begin
          cnt <= cnt + 1'b1;
          if (32'(cnt) == WORD_BITS - 1) state <= S_FIN;
        end
        S_FIN: begin
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (!out_stall) begin
          out_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* hdl/int128_signed_alu_core.sv */
// Signed 128-bit ALU: one item at a time through a shared add/shift unit.
// Add/sub/neg/compare/shift go from load to the finish state, then the registered
// output; mul/div/rem first step WORD_BITS times (one multiplier or quotient bit
// per cycle through the iteration adder). The input is stalled until the result
// is taken.
// Reset: synchronous rst clears sequencer and output valid.
module int128_signed_alu_core #(
  parameter int unsigned WORD_BITS = i128alu_pkg::WordBitsDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  i128alu_pkg::alu_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output i128alu_pkg::alu_out_t out_data
);
  import i128alu_pkg::*;

  alu_ctl_t ctl;

  i128alu_seq #(.WORD_BITS(WORD_BITS)) u_seq (
    .clk, .rst, .in_valid, .in_func(in_data.func), .out_stall,
    .in_stall, .out_valid, .ctl
  );

  i128alu_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk, .ctl, .item(in_data), .result(out_data)
  );
endmodule

/* hdl/int128_signed_alu_core_chk.sv */
// Port-level checker for the signed ALU, bound to the top level.
// Uses int128_signed_alu_core_assert.svh and i128alu_pkg.
`include "int128_signed_alu_core_assert.svh"
module int128_signed_alu_core_chk (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input i128alu_pkg::alu_out_t out_data
);
  import i128alu_pkg::*;
  `ALU_ASSERT_IMP(a_busy_when_out, out_valid, in_stall)
  `ALU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `ALU_ASSERT_NEXT(a_take_then_busy, in_valid && !in_stall, in_stall && !out_valid)
  `ALU_ASSERT_IMP(a_dz_clean, out_valid && out_data.div_zero, out_data.res_lo == 64'd0)
endmodule

bind int128_signed_alu_core int128_signed_alu_core_chk u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);
